// ----- rtl/core/bcb_pkg.sv -----
`default_nettype none
package bcb_pkg;

  // image and table geometry
  localparam int IMAGE_WIDTH  = 800;
  localparam int IMAGE_HEIGHT = 450;
  localparam int MAX_LIGHTS   = 8;

  // field widths
  localparam int X_W       = 10;
  localparam int Y_W       = 9;
  localparam int LC_W      = 4;
  localparam int FOV_W     = 16;
  localparam int ANG_W     = 16;
  localparam int TOTAL_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // kept table indexing and counts
  localparam int IDX_W = $clog2(MAX_LIGHTS);
  localparam int CNT_W = $clog2(MAX_LIGHTS + 1);
  localparam int SX_W  = X_W + $clog2(MAX_LIGHTS);
  localparam int SY_W  = Y_W + $clog2(MAX_LIGHTS);

  // bearing arithmetic: offset magnitude times fov, divided by twice the half size
  localparam int MAG_W     = 11;
  localparam int NUM_W     = MAG_W + FOV_W;
  localparam int HALF_X    = IMAGE_WIDTH / 2;
  localparam int HALF_Y    = IMAGE_HEIGHT / 2;
  localparam int DEN_X     = 2 * HALF_X;
  localparam int DEN_Y     = 2 * HALF_Y;
  localparam int DEN_MAX   = (DEN_X > DEN_Y) ? DEN_X : DEN_Y;
  localparam int DEN_W     = $clog2(DEN_MAX + 1);
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int ANGLE_MAX = 32767;

  // constant divide as a reciprocal multiply, exact for any NUM_W-bit numerator
  localparam int     RECIP_SH = NUM_W + $clog2(DEN_MAX);
  localparam int     RECIP_W  = 29;
  localparam int     PROD_W   = NUM_W + RECIP_W;
  localparam int     QB_W     = PROD_W - RECIP_SH;
  localparam longint RECIP_X  =
    ((longint'(1) << RECIP_SH) + longint'(DEN_X) - longint'(1)) / longint'(DEN_X);
  localparam longint RECIP_Y  =
    ((longint'(1) << RECIP_SH) + longint'(DEN_Y) - longint'(1)) / longint'(DEN_Y);

  // register reset values
  localparam int LIGHT_COUNT_RST = 6;
  localparam int H_FOV_RST       = 34315;
  localparam int V_FOV_RST       = 20017;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_COUNT = 2'd0,
    REG_H_FOV       = 2'd1,
    REG_V_FOV       = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [X_W-1:0] spot_x;
    logic [Y_W-1:0] spot_y;
    logic           spot_valid;
    logic           frame_end;
  } spot_t;

  typedef struct packed {
    logic                    status;
    logic                    all_found;
    logic [X_W-1:0]          center_x;
    logic [Y_W-1:0]          center_y;
    logic signed [ANG_W-1:0] yaw_angle;
    logic signed [ANG_W-1:0] pitch_angle;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic ins;
    logic sum_init;
    logic sum_step;
    logic cgo;
    logic cap;
    logic bgo;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic sum_last;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/bcb_div.sv -----
`default_nettype none
module bcb_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      go,
  input  wire logic [bcb_pkg::NUM_W-1:0] num,
  input  wire logic [bcb_pkg::DEN_W-1:0] den,
  output logic      [bcb_pkg::NUM_W-1:0] quo,
  output logic                           done
);
  import bcb_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0]     quo_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W:0]       trial;
  logic                 fits;

  // restoring step, one quotient bit per cycle
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(NUM_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], fits};
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ----- rtl/core/bcb_dp.sv -----
`default_nettype none
module bcb_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bcb_pkg::spot_t                in_data,
  input  wire logic                          cfg_we,
  input  wire logic [bcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bcb_pkg::CFG_W-1:0]     cfg_data,
  input  wire bcb_pkg::cmd_t                 cmd,
  output bcb_pkg::sts_t                      sts,
  output bcb_pkg::result_t                   out_data
);
  import bcb_pkg::*;

  logic [LC_W-1:0]    lc_r;
  logic [FOV_W-1:0]   hfov_r;
  logic [FOV_W-1:0]   vfov_r;
  logic [X_W-1:0]     kx_r [MAX_LIGHTS];
  logic [Y_W-1:0]     ky_r [MAX_LIGHTS];
  logic [TOTAL_W-1:0] total_r;
  logic [IDX_W-1:0]   idx_r;
  logic [SX_W-1:0]    sx_r;
  logic [SY_W-1:0]    sy_r;
  logic [X_W-1:0]     cx_r;
  logic [Y_W-1:0]     cy_r;
  logic [MAG_W-1:0]   magx_r;
  logic [MAG_W-1:0]   magy_r;
  logic               negx_r;
  logic               negy_r;
  logic [NUM_W-1:0]   bnumx_r;
  logic [NUM_W-1:0]   bnumy_r;
  logic [QB_W-1:0]    bqx_r;
  logic [QB_W-1:0]    bqy_r;
  result_t            out_r;

  logic [CNT_W-1:0]  eff;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  pos;
  logic [NUM_W-1:0]  numx;
  logic [NUM_W-1:0]  numy;
  logic [DEN_W-1:0]  denx;
  logic [DEN_W-1:0]  deny;
  logic [NUM_W-1:0]  qx;
  logic [NUM_W-1:0]  qy;
  logic              donex;
  logic              doney;
  logic [MAG_W-1:0]  cxw;
  logic [MAG_W-1:0]  cyw;
  logic [MAG_W-1:0]  hx;
  logic [MAG_W-1:0]  hy;
  logic [PROD_W-1:0] prodx;
  logic [PROD_W-1:0] prody;

  function automatic logic [ANG_W-1:0] angle_word(input logic [QB_W-1:0] q, input logic neg);
    logic [ANG_W-1:0] m;
    m = (q > QB_W'(ANGLE_MAX)) ? ANG_W'(ANGLE_MAX) : q[ANG_W-1:0];
    return neg ? ANG_W'(-m) : m;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r   <= LC_W'(LIGHT_COUNT_RST);
      hfov_r <= FOV_W'(H_FOV_RST);
      vfov_r <= FOV_W'(V_FOV_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIGHT_COUNT: lc_r   <= cfg_data[LC_W-1:0];
        REG_H_FOV:       hfov_r <= cfg_data[FOV_W-1:0];
        REG_V_FOV:       vfov_r <= cfg_data[FOV_W-1:0];
        default: ;
      endcase
    end
  end

  // effective light count, entries in use, lights to average
  always_comb begin
    if (lc_r == '0) begin
      eff = CNT_W'(1);
    end else if (CNT_W'(lc_r) > CNT_W'(MAX_LIGHTS)) begin
      eff = CNT_W'(MAX_LIGHTS);
    end else begin
      eff = CNT_W'(lc_r);
    end
    used = (total_r < TOTAL_W'(MAX_LIGHTS)) ? CNT_W'(total_r) : CNT_W'(MAX_LIGHTS);
    n    = (eff < used) ? eff : used;
  end

  // insert position: first kept entry whose row the new spot meets or beats
  always_comb begin
    pos = used;
    for (int i = MAX_LIGHTS - 1; i >= 0; i--) begin
      if (CNT_W'(i) < used && in_data.spot_y >= ky_r[i]) begin
        pos = CNT_W'(i);
      end
    end
  end

  // kept table, sorted best first, shifts down below the insert point
  always_ff @(posedge clk) begin
    if (cmd.ins && pos < CNT_W'(MAX_LIGHTS)) begin
      for (int i = 0; i < MAX_LIGHTS; i++) begin
        if (CNT_W'(i) == pos) begin
          kx_r[i] <= in_data.spot_x;
          ky_r[i] <= in_data.spot_y;
        end
      end
      for (int i = 1; i < MAX_LIGHTS; i++) begin
        if (CNT_W'(i) > pos) begin
          kx_r[i] <= kx_r[i-1];
          ky_r[i] <= ky_r[i-1];
        end
      end
    end
  end

  // spot count, saturating
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cmd.load) begin
      total_r <= '0;
    end else if (cmd.ins && total_r != '1) begin
      total_r <= total_r + TOTAL_W'(1);
    end
  end

  // sum of the best n entries, one per cycle
  always_ff @(posedge clk) begin
    if (cmd.sum_init) begin
      idx_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
    end else if (cmd.sum_step) begin
      idx_r <= idx_r + IDX_W'(1);
      sx_r  <= sx_r + SX_W'(kx_r[idx_r]);
      sy_r  <= sy_r + SY_W'(ky_r[idx_r]);
    end
  end

  // center average operands for the serial dividers
  assign numx = NUM_W'(sx_r);
  assign numy = NUM_W'(sy_r);
  assign denx = DEN_W'(n);
  assign deny = DEN_W'(n);

  bcb_div u_div_x (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.cgo),
    .num  (numx),
    .den  (denx),
    .quo  (qx),
    .done (donex)
  );

  bcb_div u_div_y (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.cgo),
    .num  (numy),
    .den  (deny),
    .quo  (qy),
    .done (doney)
  );

  // center offsets from the image middle as sign and magnitude
  assign cxw = MAG_W'(qx[X_W-1:0]);
  assign cyw = MAG_W'(qy[Y_W-1:0]);
  assign hx  = MAG_W'(HALF_X);
  assign hy  = MAG_W'(HALF_Y);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cx_r   <= qx[X_W-1:0];
      cy_r   <= qy[Y_W-1:0];
      negx_r <= cxw > hx;
      negy_r <= cyw > hy;
      magx_r <= (cxw > hx) ? (cxw - hx) : (hx - cxw);
      magy_r <= (cyw > hy) ? (cyw - hy) : (hy - cyw);
    end
  end

  // bearing numerators: offset magnitude times fov
  always_ff @(posedge clk) begin
    if (cmd.bgo) begin
      bnumx_r <= NUM_W'(magx_r) * NUM_W'(hfov_r);
      bnumy_r <= NUM_W'(magy_r) * NUM_W'(vfov_r);
    end
  end

  // divide by twice the half size through a reciprocal multiply, registered the cycle after the numerators
  assign prodx = PROD_W'(bnumx_r) * PROD_W'(RECIP_X);
  assign prody = PROD_W'(bnumy_r) * PROD_W'(RECIP_Y);

  always_ff @(posedge clk) begin
    bqx_r <= prodx[RECIP_SH +: QB_W];
    bqy_r <= prody[RECIP_SH +: QB_W];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (total_r == '0) begin
        out_r <= '0;
      end else begin
        out_r.status      <= 1'b1;
        out_r.all_found   <= total_r >= TOTAL_W'(eff);
        out_r.center_x    <= cx_r;
        out_r.center_y    <= cy_r;
        out_r.yaw_angle   <= angle_word(bqx_r, negx_r);
        out_r.pitch_angle <= angle_word(bqy_r, negy_r);
      end
    end
  end

  assign out_data     = out_r;
  assign sts.empty    = total_r == '0;
  assign sts.sum_last = CNT_W'(idx_r) == (n - CNT_W'(1));
  assign sts.div_done = donex & doney;

endmodule
`default_nettype wire

// ----- rtl/core/bcb_ctrl.sv -----
`default_nettype none
module bcb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire bcb_pkg::spot_t in_data,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire bcb_pkg::sts_t  sts,
  output bcb_pkg::cmd_t       cmd
);
  import bcb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_CSTART,
    S_CWAIT,
    S_BSTART,
    S_BWAIT,
    S_LOAD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   acc;

  assign acc      = in_valid && state_r == S_IDLE;
  assign in_stall = state_r != S_IDLE;

  // commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.ins      = acc && in_data.spot_valid;
    cmd.sum_init = acc && in_data.frame_end;
    cmd.sum_step = state_r == S_SUM && !sts.empty;
    cmd.cgo      = state_r == S_CSTART;
    cmd.cap      = state_r == S_CWAIT && sts.div_done;
    cmd.bgo      = state_r == S_BSTART;
    cmd.load     = state_r == S_LOAD && (!out_valid_r || !out_stall);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc && in_data.frame_end) state_nxt = S_SUM;
      end
      S_SUM: begin
        if (sts.empty) begin
          state_nxt = S_LOAD;
        end else if (sts.sum_last) begin
          state_nxt = S_CSTART;
        end
      end
      S_CSTART: state_nxt = S_CWAIT;
      S_CWAIT: begin
        if (sts.div_done) state_nxt = S_BSTART;
      end
      S_BSTART: state_nxt = S_BWAIT;
      // reciprocal multiply quotient is registered during this wait state
      S_BWAIT: state_nxt = S_LOAD;
      S_LOAD: begin
        if (cmd.load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result beat held until taken
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a pending result beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  // divider completion only in one of the two wait states
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_CWAIT || state_r == S_BWAIT))
    else $error("divider done outside a wait state");

  // no frame-end work while input beats are taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (!cmd.cgo && !cmd.bgo && !cmd.load && !cmd.sum_step))
    else $error("frame-end command while accepting input");

  // a frame end with spots leads to a division start
  a_sum_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM && !sts.empty && sts.sum_last) |=> state_r == S_CSTART)
    else $error("sum end did not start the divide");

endmodule
`default_nettype wire

// ----- rtl/core/beacon_center_bearing.sv -----
// sequence: a spot-only beat is stored as it is taken; a frame-end beat gives its
//   result after n sum steps, n = lights averaged (1..8), then the serial center
//   divide, the bearing multiplies and the load; with no spots, only the load
// throughput: one beat per cycle between frame ends; input stalls during the
//   frame-end work, including the wait to load while the last result is untaken
// reset: synchronous, active low; clears the spot count, control and registers
//   to light_count 6, horizontal_fov 34315, vertical_fov 20017
`default_nettype none
module beacon_center_bearing (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire bcb_pkg::spot_t                in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output bcb_pkg::result_t                   out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bcb_pkg::CFG_W-1:0]     cfg_data
);
  import bcb_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // register writes are taken every cycle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  bcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bcb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ----- tb/tb_beacon_center_bearing.sv -----
`default_nettype none
module tb_beacon_center_bearing;
  import bcb_pkg::*;

  localparam int SETTLE_CYCLES  = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 260;
  localparam int LONG_FRAME     = 260;
  localparam int TOTAL_MAX      = 255;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  bit clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  spot_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  result_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  beacon_center_bearing dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // free running clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: register copies and the sorted spot table
  logic [LC_W-1:0]  lights_cfg = LC_W'(LIGHT_COUNT_RST);
  logic [FOV_W-1:0] hfov_cfg   = FOV_W'(H_FOV_RST);
  logic [FOV_W-1:0] vfov_cfg   = FOV_W'(V_FOV_RST);
  logic [X_W-1:0]   kept_x [MAX_LIGHTS];
  logic [Y_W-1:0]   kept_y [MAX_LIGHTS];
  int               spots_in_frame = 0;

  // stimulus and scoreboard bookkeeping
  spot_t   spot_q[$];
  result_t bearing_q[$];
  int items_queued = 0;
  int items_taken = 0;
  int stim_items = 0;
  int frames_checked = 0;
  int reg_writes = 0;
  int input_stalls = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int stall_left = 0;
  bit spot_beat_taken = 1'b0;

  // offset from image center times fov over the full image size, truncated toward zero and clamped
  function automatic logic signed [ANG_W-1:0] bearing_of(int center, int half, int fov);
    longint v;
    v = ((longint'(half) - center) * fov) / (2 * half);
    if (v > ANGLE_MAX) v = ANGLE_MAX;
    if (v < -ANGLE_MAX) v = -ANGLE_MAX;
    return ANG_W'(v);
  endfunction

  // take one beat into the frame; returns 1 with the frame result on a frame end
  function automatic bit predict_bearing(spot_t s, output result_t r);
    int used, pos, last, eff, n, sum_x, sum_y, cx, cy;
    r = '0;
    used = (spots_in_frame < MAX_LIGHTS) ? spots_in_frame : MAX_LIGHTS;
    if (s.spot_valid) begin
      // first slot whose row is not above the new one; later ties rank higher
      pos = used;
      for (int i = used - 1; i >= 0; i--)
        if (s.spot_y >= kept_y[i]) pos = i;
      if (pos < MAX_LIGHTS) begin
        last = (used < MAX_LIGHTS) ? used : MAX_LIGHTS - 1;
        for (int i = last; i > pos; i--) begin
          kept_x[i] = kept_x[i-1];
          kept_y[i] = kept_y[i-1];
        end
        kept_x[pos] = s.spot_x;
        kept_y[pos] = s.spot_y;
      end
      if (spots_in_frame < TOTAL_MAX) spots_in_frame++;
    end
    if (!s.frame_end) return 1'b0;
    if (spots_in_frame != 0) begin
      eff = (lights_cfg == 0) ? 1 : int'(lights_cfg);
      if (eff > MAX_LIGHTS) eff = MAX_LIGHTS;
      n = (eff < spots_in_frame) ? eff : spots_in_frame;
      sum_x = 0;
      sum_y = 0;
      for (int i = 0; i < n; i++) begin
        sum_x += kept_x[i];
        sum_y += kept_y[i];
      end
      cx = sum_x / n;
      cy = sum_y / n;
      r.status      = 1'b1;
      r.all_found   = (spots_in_frame >= eff);
      r.center_x    = X_W'(cx);
      r.center_y    = Y_W'(cy);
      r.yaw_angle   = bearing_of(cx, IMAGE_WIDTH / 2, hfov_cfg);
      r.pitch_angle = bearing_of(cy, IMAGE_HEIGHT / 2, vfov_cfg);
    end
    spots_in_frame = 0;
    return 1'b1;
  endfunction

  function automatic void check_result(result_t want, result_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.all_found !== want.all_found) begin
      $error("all_found: expected %0d, got %0d", want.all_found, got.all_found);
      mismatches++;
    end
    if (got.center_x !== want.center_x) begin
      $error("center_x: expected %0d, got %0d", want.center_x, got.center_x);
      mismatches++;
    end
    if (got.center_y !== want.center_y) begin
      $error("center_y: expected %0d, got %0d", want.center_y, got.center_y);
      mismatches++;
    end
    if (got.yaw_angle !== want.yaw_angle) begin
      $error("yaw_angle: expected %0d, got %0d", want.yaw_angle, got.yaw_angle);
      mismatches++;
    end
    if (got.pitch_angle !== want.pitch_angle) begin
      $error("pitch_angle: expected %0d, got %0d", want.pitch_angle, got.pitch_angle);
      mismatches++;
    end
  endfunction

  // monitor: beats on all three channels, scoreboard and watchdog
  always @(posedge clk) begin
    result_t predicted;
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && in_stall) input_stalls++;
      if (in_valid && !in_stall) begin
        spot_beat_taken = 1'b1;
        items_taken++;
        quiet_cycles = 0;
        if (predict_bearing(in_data, predicted)) bearing_q = {bearing_q, predicted};
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (bearing_q.size() == 0) begin
          $error("result beat with no frame end pending");
          mismatches++;
        end else begin
          check_result(bearing_q.pop_front(), out_data);
          frames_checked++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        quiet_cycles = 0;
        reg_writes++;
        case (cfg_index)
          REG_LIGHT_COUNT: lights_cfg = cfg_data[LC_W-1:0];
          REG_H_FOV:       hfov_cfg = cfg_data;
          REG_V_FOV:       vfov_cfg = cfg_data;
          default:         ;
        endcase
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_beacon_center_bearing: errors");
        $finish;
      end
    end
  end

  // spot driver: holds a stalled beat, otherwise maybe idles, else sends the next
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || spot_beat_taken) begin
      if (spot_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= spot_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    spot_beat_taken = 1'b0;
  end

  // result side stall: random, or a long hold-off on request
  always @(negedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_spot(int x, int y, bit valid, bit fend);
    spot_t s;
    s.spot_x     = X_W'(x);
    s.spot_y     = Y_W'(y);
    s.spot_valid = valid;
    s.frame_end  = fend;
    spot_q = {spot_q, s};
    items_queued++;
    if (valid || fend) stim_items++;
  endtask

  // mostly inside the image, some anywhere in the field range, some on shared rows
  task automatic push_random_spot(bit fend);
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)
      push_spot($urandom_range(IMAGE_WIDTH - 1), $urandom_range(IMAGE_HEIGHT - 1), 1'b1, fend);
    else if (pick < 85)
      push_spot($urandom_range(1023), $urandom_range(511), 1'b1, fend);
    else
      push_spot($urandom_range(1023), 100 + $urandom_range(2), 1'b1, fend);
  endtask

  // one frame: spots with stray empty beats, ended on the last spot or a bare end
  task automatic queue_frame(int spots);
    bit end_on_spot;
    end_on_spot = (spots != 0) && ($urandom_range(1) == 1);
    for (int i = 0; i < spots; i++) begin
      push_random_spot(end_on_spot && (i == spots - 1));
      if ($urandom_range(19) == 0)
        push_spot($urandom_range(1023), $urandom_range(511), 1'b0, 1'b0);
    end
    if (!end_on_spot) push_spot($urandom_range(1023), $urandom_range(511), 1'b0, 1'b1);
  endtask

  // every beat accepted and every result back, then let the block settle
  task automatic drain();
    do @(negedge clk); while (items_taken != items_queued || bearing_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic run_phase(int lc, logic [CFG_W-1:0] h, logic [CFG_W-1:0] v, int idle,
                           int stall, bit pressure, bit long_frame, bit touch_unused);
    int target;
    drain();
    write_reg(REG_LIGHT_COUNT, {12'($urandom), 4'(lc)});
    write_reg(REG_H_FOV, h);
    write_reg(REG_V_FOV, v);
    if (touch_unused) write_reg(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    if (pressure) hold_requests++;
    target = stim_items + PHASE_ITEMS;
    if (long_frame) queue_frame(LONG_FRAME);
    while (stim_items < target) queue_frame($urandom_range(12));
  endtask

  initial begin
    for (int i = 0; i < MAX_LIGHTS; i++) begin
      kept_x[i] = '0;
      kept_y[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames under reset register values
    push_spot(0, 0, 1'b0, 1'b1);
    push_spot(0, 0, 1'b1, 1'b1);
    push_spot(1023, 511, 1'b1, 1'b1);
    push_spot(799, 449, 1'b1, 1'b0);
    push_spot(400, 225, 1'b1, 1'b1);
    push_spot(100, 200, 1'b1, 1'b0);
    push_spot(300, 200, 1'b1, 1'b0);
    push_spot(5, 7, 1'b0, 1'b0);
    push_spot(500, 200, 1'b1, 1'b0);
    push_spot(0, 0, 1'b0, 1'b1);
    for (int i = 0; i < 9; i++) push_spot(i * 90, (i % 3) * 150, 1'b1, i == 8);

    // random phases across register settings and idle patterns
    run_phase(1, 16'd0, 16'd0, 0, 0, 1'b0, 1'b0, 1'b0);
    run_phase(8, 16'hffff, 16'hffff, 50, 0, 1'b0, 1'b1, 1'b0);
    run_phase(0, 16'($urandom), 16'($urandom), 0, 50, 1'b0, 1'b0, 1'b0);
    run_phase(15, 16'hffff, 16'd1, 14, 14, 1'b0, 1'b0, 1'b0);
    run_phase($urandom_range(1, 8), 16'(H_FOV_RST), 16'(V_FOV_RST), 0, 0, 1'b1, 1'b0, 1'b0);
    run_phase(5, 16'($urandom), 16'($urandom), 14, 14, 1'b0, 1'b1, 1'b1);
    run_phase($urandom_range(15), 16'($urandom), 16'($urandom), 0, 0, 1'b0, 1'b0, 1'b0);
    drain();

    $display("run covered %0d spot beats (%0d frames checked) over 7 register settings",
             items_taken, frames_checked);
    $display("%0d register writes, %0d cycles with the input held back",
             reg_writes, input_stalls);
    if (mismatches == 0) begin
      $display("tb_beacon_center_bearing: clean");
    end else begin
      $display("tb_beacon_center_bearing: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
